/* sv/bspc_pkg.sv */
// Shared constants, codes and word types for the buffer slot pool.
package bspc_pkg;

  localparam int SLOT_COUNT    = 8;
  localparam int SLOT_W        = 3;
  localparam int STATE_W       = 2;
  localparam int CMD_W         = 3;
  localparam int PAYLOAD_CHARS = 5;
  localparam int PAYLOAD_W     = 40;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = 1;
  localparam int QCNT_W        = 2;

  localparam logic [PAYLOAD_W-1:0] PAYLOAD_MASK =
    {PAYLOAD_W{1'b1}} >> (PAYLOAD_W - 8 * PAYLOAD_CHARS);

  localparam logic [CMD_W-1:0] CMD_REQUEST = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FILL    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_COMPACT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STATUS  = 3'd4;

  localparam logic [STATE_W-1:0] ST_FREE  = 2'd0;
  localparam logic [STATE_W-1:0] ST_AWAIT = 2'd1;
  localparam logic [STATE_W-1:0] ST_OCC   = 2'd2;

  typedef enum logic [2:0] {
    OP_REQUEST,
    OP_FILL,
    OP_RELEASE,
    OP_COMPACT,
    OP_STATUS,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STATUS_RD,
    S_COMPACT,
    S_FLUSH
  } back_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [SLOT_W-1:0]    slot;
    logic [PAYLOAD_W-1:0] payload_in;
  } in_word_t;

  typedef struct packed {
    logic                 ok;
    logic [SLOT_W-1:0]    slot_out;
    logic [STATE_W-1:0]   slot_state_out;
    logic [PAYLOAD_W-1:0] payload_out;
  } out_word_t;

  typedef struct packed {
    op_t                  op;
    logic                 in_range;
    logic [SLOT_W-1:0]    slot;
    logic [PAYLOAD_W-1:0] payload;
  } task_t;

  typedef struct packed {
    logic  valid;
    task_t item;
  } qhead_t;

endpackage

/* sv/bspc_ram.sv */
// Generic single write port, single read port RAM with registered read.
module bspc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/bspc_front.sv */
// Command front end: accept, decode into a task, and queue for the back end.
module bspc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bspc_pkg::in_word_t in_word,
  output bspc_pkg::qhead_t   head,
  input  logic               pop
);

  bspc_pkg::task_t             q_r [bspc_pkg::QUEUE_DEPTH];
  logic [bspc_pkg::QPTR_W-1:0] head_r, head_nxt;
  logic [bspc_pkg::QPTR_W-1:0] tail_r, tail_nxt;
  logic [bspc_pkg::QCNT_W-1:0] count_r, count_nxt;
  bspc_pkg::task_t             dec;
  logic                        push;
  logic                        do_pop;

  always_comb begin
    dec.slot     = in_word.slot;
    dec.payload  = in_word.payload_in & bspc_pkg::PAYLOAD_MASK;
    dec.in_range = (int'(in_word.slot) < bspc_pkg::SLOT_COUNT);
    unique case (in_word.cmd)
      bspc_pkg::CMD_REQUEST: dec.op = bspc_pkg::OP_REQUEST;
      bspc_pkg::CMD_FILL:    dec.op = bspc_pkg::OP_FILL;
      bspc_pkg::CMD_RELEASE: dec.op = bspc_pkg::OP_RELEASE;
      bspc_pkg::CMD_COMPACT: dec.op = bspc_pkg::OP_COMPACT;
      bspc_pkg::CMD_STATUS:  dec.op = bspc_pkg::OP_STATUS;
      default:               dec.op = bspc_pkg::OP_NONE;
    endcase
  end

  assign busy   = (count_r == bspc_pkg::QCNT_W'(bspc_pkg::QUEUE_DEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (count_r != '0);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (push) begin
      tail_nxt = (tail_r == bspc_pkg::QPTR_W'(bspc_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : tail_r + 1'b1;
    end
    if (do_pop) begin
      head_nxt = (head_r == bspc_pkg::QPTR_W'(bspc_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : head_r + 1'b1;
    end
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
    if (push) begin
      q_r[tail_r] <= dec;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.item  = q_r[head_r];

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bspc_pkg::QCNT_W'(bspc_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy && !do_pop |=> count_r == bspc_pkg::QCNT_W'(bspc_pkg::QUEUE_DEPTH))
    else $error("full queue changed without a pop");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from an empty queue");
`endif

endmodule

/* sv/bspc_back.sv */
// Command back end: slot state table, payload RAM, compaction walk, results.
module bspc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bspc_pkg::qhead_t    head,
  output logic                pop,
  output logic                out_strobe,
  output bspc_pkg::out_word_t out_word
);

  bspc_pkg::back_state_t        state_r, state_nxt;
  logic [bspc_pkg::STATE_W-1:0] st_r   [bspc_pkg::SLOT_COUNT];
  logic [bspc_pkg::STATE_W-1:0] st_nxt [bspc_pkg::SLOT_COUNT];
  logic [bspc_pkg::SLOT_W-1:0]  i_r, i_nxt;
  logic [bspc_pkg::SLOT_W-1:0]  w_r, w_nxt;
  logic                         pend_r, pend_nxt;
  logic [bspc_pkg::SLOT_W-1:0]  pend_dst_r, pend_dst_nxt;
  logic                         out_valid_r, out_valid_nxt;
  bspc_pkg::out_word_t          out_r, out_nxt;

  logic                           ram_we;
  logic [bspc_pkg::SLOT_W-1:0]    ram_waddr;
  logic [bspc_pkg::PAYLOAD_W-1:0] ram_wdata;
  logic [bspc_pkg::SLOT_W-1:0]    ram_raddr;
  logic [bspc_pkg::PAYLOAD_W-1:0] ram_rdata;

  logic                         free_found;
  logic [bspc_pkg::SLOT_W-1:0]  free_idx;
  logic [bspc_pkg::STATE_W-1:0] cur_st;
  bspc_pkg::task_t              t;

  bspc_ram #(
    .WIDTH (bspc_pkg::PAYLOAD_W),
    .DEPTH (bspc_pkg::SLOT_COUNT)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign t      = head.item;
  assign cur_st = st_r[t.slot];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = bspc_pkg::SLOT_COUNT - 1; k >= 0; k--) begin
      if (st_r[k] == bspc_pkg::ST_FREE) begin
        free_found = 1'b1;
        free_idx   = bspc_pkg::SLOT_W'(k);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bspc_pkg::S_IDLE: begin
        if (head.valid) begin
          if (t.op == bspc_pkg::OP_STATUS) begin
            state_nxt = bspc_pkg::S_STATUS_RD;
          end else if (t.op == bspc_pkg::OP_COMPACT) begin
            state_nxt = bspc_pkg::S_COMPACT;
          end
        end
      end
      bspc_pkg::S_STATUS_RD: state_nxt = bspc_pkg::S_IDLE;
      bspc_pkg::S_COMPACT: begin
        if (i_r == '0) begin
          state_nxt = bspc_pkg::S_FLUSH;
        end
      end
      bspc_pkg::S_FLUSH: state_nxt = bspc_pkg::S_IDLE;
      default: state_nxt = bspc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    i_nxt         = i_r;
    w_nxt         = w_r;
    pend_nxt      = 1'b0;
    pend_dst_nxt  = pend_dst_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = pend_dst_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = '0;
    unique case (state_r)
      bspc_pkg::S_IDLE: begin
        ram_raddr = t.slot;
        if (head.valid) begin
          pop     = 1'b1;
          out_nxt = '0;
          unique case (t.op)
            bspc_pkg::OP_REQUEST: begin
              out_valid_nxt = 1'b1;
              if (free_found) begin
                st_nxt[free_idx]       = bspc_pkg::ST_AWAIT;
                out_nxt.ok             = 1'b1;
                out_nxt.slot_out       = free_idx;
                out_nxt.slot_state_out = bspc_pkg::ST_AWAIT;
              end
            end
            bspc_pkg::OP_FILL: begin
              out_valid_nxt    = 1'b1;
              out_nxt.slot_out = t.slot;
              if (t.in_range) begin
                out_nxt.slot_state_out = cur_st;
                if (cur_st == bspc_pkg::ST_AWAIT) begin
                  st_nxt[t.slot]         = bspc_pkg::ST_OCC;
                  out_nxt.ok             = 1'b1;
                  out_nxt.slot_state_out = bspc_pkg::ST_OCC;
                  ram_we                 = 1'b1;
                  ram_waddr              = t.slot;
                  ram_wdata              = t.payload;
                end
              end
            end
            bspc_pkg::OP_RELEASE: begin
              out_valid_nxt    = 1'b1;
              out_nxt.slot_out = t.slot;
              if (t.in_range) begin
                out_nxt.slot_state_out = cur_st;
                if (cur_st == bspc_pkg::ST_OCC) begin
                  st_nxt[t.slot]         = bspc_pkg::ST_FREE;
                  out_nxt.ok             = 1'b1;
                  out_nxt.slot_state_out = bspc_pkg::ST_FREE;
                end
              end
            end
            bspc_pkg::OP_STATUS: begin
              // payload filled in once the RAM read returns
              out_nxt.slot_out = t.slot;
              if (t.in_range) begin
                out_nxt.ok             = 1'b1;
                out_nxt.slot_state_out = cur_st;
              end
            end
            bspc_pkg::OP_COMPACT: begin
              i_nxt = bspc_pkg::SLOT_W'(bspc_pkg::SLOT_COUNT - 1);
              w_nxt = bspc_pkg::SLOT_W'(bspc_pkg::SLOT_COUNT - 1);
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      bspc_pkg::S_STATUS_RD: begin
        out_valid_nxt = 1'b1;
        if (out_r.ok && out_r.slot_state_out == bspc_pkg::ST_OCC) begin
          out_nxt.payload_out = ram_rdata;
        end
      end
      bspc_pkg::S_COMPACT: begin
        // walk down from the top; used slots pack toward the top at w_r,
        // their payload follows from the registered RAM read of i_r
        ram_raddr = i_r;
        ram_we    = pend_r;
        if (st_r[i_r] != bspc_pkg::ST_FREE) begin
          if (w_r != i_r) begin
            st_nxt[i_r] = bspc_pkg::ST_FREE;
          end
          st_nxt[w_r]  = st_r[i_r];
          pend_nxt     = 1'b1;
          pend_dst_nxt = w_r;
          w_nxt        = w_r - 1'b1;
        end
        i_nxt = i_r - 1'b1;
      end
      bspc_pkg::S_FLUSH: begin
        ram_we        = pend_r;
        out_valid_nxt = 1'b1;
        out_nxt       = '0;
        out_nxt.ok    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bspc_pkg::S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < bspc_pkg::SLOT_COUNT; k++) begin
        st_r[k] <= bspc_pkg::ST_FREE;
      end
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
    i_r        <= i_nxt;
    w_r        <= w_nxt;
    pend_dst_r <= pend_dst_nxt;
    out_r      <= out_nxt;
  end

  assign out_strobe = out_valid_r;
  assign out_word   = out_r;

`ifndef SYNTH
  a_result_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == bspc_pkg::S_IDLE)
    else $error("result strobe outside idle");
  a_flush_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bspc_pkg::S_FLUSH |=> out_valid_r && out_r.ok)
    else $error("compaction ended without a result");
  a_payload_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.payload_out != '0 |-> out_r.slot_state_out == bspc_pkg::ST_OCC)
    else $error("payload shown for a slot that is not occupied");
  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bspc_pkg::S_COMPACT |-> w_r >= i_r)
    else $error("compaction destination below source");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == bspc_pkg::S_IDLE && head.valid)
    else $error("task taken while back end busy");
`endif

endmodule

/* sv/buffer_slot_pool_with_compaction_core.sv */
// Top level of the buffer slot pool: command queue front end and pool back end.
// Results: request, fill, release and unknown commands register a result when taken;
// status first reads the payload RAM in S_STATUS_RD; compact walks the slots in
// S_COMPACT, then registers its result in S_FLUSH. One simple command per cycle while
// the back end is idle; status and compact hold it; the walk moves one slot per cycle.
// Reset (rst_n, synchronous, active low) frees all slots, empties queue; no result stall.
module buffer_slot_pool_with_compaction_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bspc_pkg::in_word_t  in_word,
  output logic                out_strobe,
  output bspc_pkg::out_word_t out_word
);

  // decoded command at the queue head, and its take signal
  bspc_pkg::qhead_t head;
  logic             pop;

  // front: decodes each accepted word and holds up to QUEUE_DEPTH of them;
  // busy rises only when that queue is full
  bspc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_word (in_word),
    .head    (head),
    .pop     (pop)
  );

  // back: owns slot states (flip-flops) and payloads (RAM), runs one command
  // at a time and registers its result word
  bspc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule
